### hdl/wall_follow_pd_drive_unit_defines.svh
// Assertion macros for the wall-following PD drive unit.
// Used by the port checker; no other dependencies.
`ifndef WALL_FOLLOW_PD_DRIVE_UNIT_DEFINES_SVH
`define WALL_FOLLOW_PD_DRIVE_UNIT_DEFINES_SVH

// same-cycle implication
`define WFPD_ASSERT_NOW(lbl, ck, rn, ant, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ant) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define WFPD_ASSERT_NEXT(lbl, ck, rn, ant, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ant) |=> (cons)) \
    else $error(msg);

`endif

### hdl/wfpd_pkg.sv
// Shared types, register indexes, reset values and codes for the wall-following drive unit.
// No dependencies.
package wfpd_pkg;

  localparam int SENSOR_LIMIT_DEF = 2000;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_STOP_DIST   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_DIST = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_SPEED  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D      = 3'd5;

  localparam logic [11:0]        STOP_DIST_RST   = 12'd100;
  localparam logic [11:0]        TARGET_DIST_RST = 12'd150;
  localparam logic signed [7:0]  BASE_SPEED_RST  = 8'sd80;
  localparam logic [31:0]        TIMEOUT_RST     = 32'd3000;
  localparam logic signed [15:0] GAIN_P_RST      = 16'sd128;
  localparam logic signed [15:0] GAIN_D_RST      = 16'sd26;

  localparam logic [1:0] CAUSE_NONE    = 2'd0;
  localparam logic [1:0] CAUSE_FRONT   = 2'd1;
  localparam logic [1:0] CAUSE_TIMEOUT = 2'd2;

  // x/10 for 0 <= x <= 768 as (x * 205) >> 11
  localparam logic [17:0] DIV10_MUL = 18'd205;
  localparam int          DIV10_SH  = 11;

  typedef logic signed [13:0] err_t;

  typedef struct packed {
    logic [11:0]        stop_dist_mm;
    logic [11:0]        target_dist_mm;
    logic signed [7:0]  base_speed;
    logic [31:0]        timeout_ms;
    logic signed [15:0] gain_p;
    logic signed [15:0] gain_d;
  } cfg_t;

  typedef struct packed {
    logic        start_req;
    logic [31:0] now_ms;
    logic [15:0] front_mm;
    logic        side_present;
    logic [15:0] side_mm;
  } item_t;

  typedef struct packed {
    logic               steer;
    logic [1:0]         cause;
    logic signed [29:0] prod_p;
    logic signed [30:0] prod_d;
  } prod_t;

endpackage

### hdl/wfpd_if.sv
// Valid/ready channel interfaces for tick items and drive results.
// No dependencies.
interface wfpd_in_if;
  logic        valid;
  logic        ready;
  logic        start_req;
  logic [31:0] now_ms;
  logic [15:0] front_mm;
  logic        side_present;
  logic [15:0] side_mm;

  modport source (output valid, start_req, now_ms, front_mm, side_present, side_mm,
                  input ready);
  modport sink   (input valid, start_req, now_ms, front_mm, side_present, side_mm,
                  output ready);
endinterface

interface wfpd_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] left_speed;
  logic [6:0] right_speed;
  logic       finished;
  logic [1:0] stop_cause;

  modport source (output valid, left_speed, right_speed, finished, stop_cause,
                  input ready);
  modport sink   (input valid, left_speed, right_speed, finished, stop_cause,
                  output ready);
endinterface

### hdl/wall_follow_pd_drive_unit.sv
// Wall-following PD drive unit: three-stage pipeline, one result per tick transfer.
// An input transfer passes the input, product and result registers, in order, to the output.
// One item per cycle unless stalled; move state updates as items enter the product stage.
// Each stage advances when empty or when the one after it moves, so stalls collapse bubbles.
// Reset (rst_n low, synchronous): pipeline empty, move idle, registers at their defaults.
// Depends on wfpd_pkg, wfpd_if, wfpd_steer and wfpd_mix.
module wall_follow_pd_drive_unit #(
  parameter int SENSOR_LIMIT_MM = wfpd_pkg::SENSOR_LIMIT_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [wfpd_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [wfpd_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  wfpd_in_if.sink                          in_ch,
  wfpd_out_if.source                       out_ch
);
  import wfpd_pkg::*;

  cfg_t        cfg_r;
  logic        a_v_r;
  item_t       a_item_r;
  logic        b_v_r;
  prod_t       b_prod_r;
  logic        out_v_r;
  logic [6:0]  left_r;
  logic [6:0]  right_r;
  logic        fin_r;
  logic [1:0]  cause_r;

  logic [31:0] start_time_r;
  err_t        prev_error_r;
  logic        running_r;
  logic [31:0] start_time_nxt;
  err_t        prev_error_nxt;
  logic        running_nxt;

  logic        out_en;
  logic        b_en;
  logic        a_en;
  prod_t       prod;
  item_t       in_item;
  logic [6:0]  left_nxt;
  logic [6:0]  right_nxt;
  logic        fin_nxt;
  logic [1:0]  cause_nxt;

  assign out_en = !out_v_r || out_ch.ready;
  assign b_en   = !b_v_r || out_en;
  assign a_en   = !a_v_r || b_en;

  assign in_ch.ready          = a_en;
  assign in_item.start_req    = in_ch.start_req;
  assign in_item.now_ms       = in_ch.now_ms;
  assign in_item.front_mm     = in_ch.front_mm;
  assign in_item.side_present = in_ch.side_present;
  assign in_item.side_mm      = in_ch.side_mm;

  assign out_ch.valid       = out_v_r;
  assign out_ch.left_speed  = left_r;
  assign out_ch.right_speed = right_r;
  assign out_ch.finished    = fin_r;
  assign out_ch.stop_cause  = cause_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.stop_dist_mm   <= STOP_DIST_RST;
      cfg_r.target_dist_mm <= TARGET_DIST_RST;
      cfg_r.base_speed     <= BASE_SPEED_RST;
      cfg_r.timeout_ms     <= TIMEOUT_RST;
      cfg_r.gain_p         <= GAIN_P_RST;
      cfg_r.gain_d         <= GAIN_D_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_STOP_DIST:   cfg_r.stop_dist_mm   <= cfg_wdata[11:0];
        CFG_TARGET_DIST: cfg_r.target_dist_mm <= cfg_wdata[11:0];
        CFG_BASE_SPEED:  cfg_r.base_speed     <= cfg_wdata[7:0];
        CFG_TIMEOUT:     cfg_r.timeout_ms     <= cfg_wdata[31:0];
        CFG_GAIN_P:      cfg_r.gain_p         <= cfg_wdata[15:0];
        CFG_GAIN_D:      cfg_r.gain_d         <= cfg_wdata[15:0];
        default: begin
        end
      endcase
    end
  end

  wfpd_steer #(
    .SENSOR_LIMIT_MM (SENSOR_LIMIT_MM)
  ) u_steer (
    .item           (a_item_r),
    .cfg            (cfg_r),
    .start_time_r   (start_time_r),
    .prev_error_r   (prev_error_r),
    .running_r      (running_r),
    .prod           (prod),
    .start_time_nxt (start_time_nxt),
    .prev_error_nxt (prev_error_nxt),
    .running_nxt    (running_nxt)
  );

  wfpd_mix u_mix (
    .prod        (b_prod_r),
    .base_speed  (cfg_r.base_speed),
    .left_speed  (left_nxt),
    .right_speed (right_nxt),
    .finished    (fin_nxt),
    .stop_cause  (cause_nxt)
  );

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r        <= 1'b0;
      b_v_r        <= 1'b0;
      out_v_r      <= 1'b0;
      start_time_r <= '0;
      prev_error_r <= '0;
      running_r    <= 1'b0;
    end else begin
      if (a_en) begin
        a_v_r <= in_ch.valid;
      end
      if (b_en) begin
        b_v_r <= a_v_r;
      end
      if (out_en) begin
        out_v_r <= b_v_r;
      end
      if (b_en && a_v_r) begin
        start_time_r <= start_time_nxt;
        prev_error_r <= prev_error_nxt;
        running_r    <= running_nxt;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (a_en && in_ch.valid) begin
      a_item_r <= in_item;
    end
    if (b_en && a_v_r) begin
      b_prod_r <= prod;
    end
    if (out_en && b_v_r) begin
      left_r  <= left_nxt;
      right_r <= right_nxt;
      fin_r   <= fin_nxt;
      cause_r <= cause_nxt;
    end
  end

endmodule

### hdl/wfpd_steer.sv
// Stop decision, side error, derivative and the two gain products for one tick.
// Depends on wfpd_pkg.
module wfpd_steer #(
  parameter int SENSOR_LIMIT_MM = wfpd_pkg::SENSOR_LIMIT_DEF
) (
  input  wfpd_pkg::item_t item,
  input  wfpd_pkg::cfg_t  cfg,
  input  logic [31:0]     start_time_r,
  input  wfpd_pkg::err_t  prev_error_r,
  input  logic            running_r,
  output wfpd_pkg::prod_t prod,
  output logic [31:0]     start_time_nxt,
  output wfpd_pkg::err_t  prev_error_nxt,
  output logic            running_nxt
);
  import wfpd_pkg::*;

  localparam logic [15:0] LIMIT = 16'(SENSOR_LIMIT_MM);

  logic               eff_run;
  err_t               eff_prev;
  logic [31:0]        elapsed;
  logic               tmo;
  logic               front_hit;
  logic               side_ok;
  logic signed [16:0] diff;
  err_t               diff_sat;
  err_t               err;
  logic signed [14:0] deriv;
  logic               steer;

  always_comb begin
    start_time_nxt = item.start_req ? item.now_ms : start_time_r;
    eff_prev       = item.start_req ? err_t'(0) : prev_error_r;
    eff_run        = item.start_req | running_r;
    elapsed        = item.now_ms - start_time_nxt;
    tmo            = elapsed >= cfg.timeout_ms;
    front_hit      = (item.front_mm < LIMIT) && (item.front_mm <= {4'd0, cfg.stop_dist_mm});

    diff = $signed({5'd0, cfg.target_dist_mm}) - $signed({1'b0, item.side_mm});
    priority if (diff > 17'sd8191) begin
      diff_sat = 14'sd8191;
    end else if (diff < -17'sd8192) begin
      diff_sat = -14'sd8192;
    end else begin
      diff_sat = diff[13:0];
    end
    side_ok = item.side_present && (item.side_mm < LIMIT);
    err     = side_ok ? diff_sat : err_t'(0);
    deriv   = 15'(err) - 15'(eff_prev);

    steer = eff_run && !tmo && !front_hit;

    prod.steer = steer;
    priority if (!eff_run) begin
      prod.cause = CAUSE_NONE;
    end else if (tmo) begin
      prod.cause = CAUSE_TIMEOUT;
    end else if (front_hit) begin
      prod.cause = CAUSE_FRONT;
    end else begin
      prod.cause = CAUSE_NONE;
    end
    prod.prod_p = 30'(cfg.gain_p) * 30'(err);
    prod.prod_d = 31'(cfg.gain_d) * 31'(deriv);

    prev_error_nxt = steer ? err : eff_prev;
    running_nxt    = steer;
  end

endmodule

### hdl/wfpd_mix.sv
// PD sum, truncating scale, correction limit and left/right speed clamps.
// Depends on wfpd_pkg.
module wfpd_mix (
  input  wfpd_pkg::prod_t   prod,
  input  logic signed [7:0] base_speed,
  output logic [6:0]        left_speed,
  output logic [6:0]        right_speed,
  output logic              finished,
  output logic [1:0]        stop_cause
);
  import wfpd_pkg::*;

  logic signed [31:0] acc;
  logic signed [31:0] rnd;
  logic signed [23:0] corr;
  logic [7:0]         mag;
  logic [9:0]         mag6;
  logic [17:0]        scaled;
  logic [6:0]         q;
  logic [6:0]         lim;
  logic signed [23:0] lim_s;
  logic signed [7:0]  corr_c;
  logic signed [9:0]  ls;
  logic signed [9:0]  rs;
  logic [6:0]         ls_c;
  logic [6:0]         rs_c;

  function automatic logic [6:0] clamp_speed(input logic signed [9:0] v);
    logic [6:0] r;
    priority if (v < 10'sd0) begin
      r = 7'd0;
    end else if (v > 10'sd127) begin
      r = 7'd127;
    end else begin
      r = v[6:0];
    end
    return r;
  endfunction

  always_comb begin
    acc  = 32'(prod.prod_p) + 32'(prod.prod_d);
    rnd  = acc + (acc[31] ? 32'sd255 : 32'sd0);
    corr = rnd[31:8];

    mag    = base_speed[7] ? 8'(-base_speed) : base_speed;
    mag6   = {mag, 2'b00} + {1'b0, mag, 1'b0};
    scaled = 18'(mag6) * DIV10_MUL;
    q      = scaled[DIV10_SH +: 7];
    lim    = (base_speed[7] || (base_speed == 8'sd0) || (q == 7'd0)) ? 7'd1 : q;
    lim_s  = $signed({17'd0, lim});

    priority if (corr > lim_s) begin
      corr_c = 8'(lim_s);
    end else if (corr < -lim_s) begin
      corr_c = 8'(-lim_s);
    end else begin
      corr_c = corr[7:0];
    end

    ls   = 10'(base_speed) - 10'(corr_c);
    rs   = 10'(base_speed) + 10'(corr_c);
    ls_c = clamp_speed(ls);
    rs_c = clamp_speed(rs);

    left_speed  = prod.steer ? ls_c : 7'd0;
    right_speed = prod.steer ? rs_c : 7'd0;
    finished    = !prod.steer;
    stop_cause  = prod.cause;
  end

endmodule

### hdl/wfpd_checker.sv
// Port-level checker for the wall-following drive unit, bound to the top level.
// Depends on wfpd_pkg and wall_follow_pd_drive_unit_defines.svh.
`include "wall_follow_pd_drive_unit_defines.svh"

module wfpd_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [6:0] left_speed,
  input logic [6:0] right_speed,
  input logic       finished,
  input logic [1:0] stop_cause
);
  import wfpd_pkg::*;

  `WFPD_ASSERT_NOW(a_fin_zero, clk, rst_n, out_valid && finished, (left_speed == 7'd0) && (right_speed == 7'd0), "finished result with nonzero speed")
  `WFPD_ASSERT_NOW(a_run_no_cause, clk, rst_n, out_valid && !finished, stop_cause == CAUSE_NONE, "running result reports a stop cause")
  `WFPD_ASSERT_NOW(a_cause_fin, clk, rst_n, out_valid && (stop_cause != CAUSE_NONE), finished, "stop cause without finished")
  `WFPD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(left_speed) && $stable(right_speed) && $stable(finished) && $stable(stop_cause), "stalled result changed")

endmodule

bind wall_follow_pd_drive_unit wfpd_checker u_wfpd_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .left_speed  (out_ch.left_speed),
  .right_speed (out_ch.right_speed),
  .finished    (out_ch.finished),
  .stop_cause  (out_ch.stop_cause)
);
